>>> rtl/ssam_pkg.sv
package ssam_pkg;

  localparam int IdWidth      = 5;
  localparam int TicksWidth   = 16;
  localparam int CfgDataWidth = 16;
  localparam int CfgIdxWidth  = 1;
  localparam int FrameLen     = 3;

  localparam logic [CfgIdxWidth-1:0] REG_SERVO_ID      = 1'd0;
  localparam logic [CfgIdxWidth-1:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic [TicksWidth-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TicksWidth-1:0] COUNT_MAX     = 16'hFFFF;

  localparam logic [7:0] CMD_POS  = 8'h80;
  localparam logic [7:0] CMD_RD   = 8'hA0;
  localparam logic [7:0] SUB_CUR  = 8'h03;
  localparam logic [7:0] SUB_TEMP = 8'h04;

  localparam logic [2:0] FUNC_REQ_POS  = 3'd0;
  localparam logic [2:0] FUNC_REQ_CUR  = 3'd1;
  localparam logic [2:0] FUNC_REQ_TEMP = 3'd2;
  localparam logic [2:0] FUNC_SEND     = 3'd3;
  localparam logic [2:0] FUNC_RX_BYTE  = 3'd4;
  localparam logic [2:0] FUNC_TICK     = 3'd5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_VERIFY   = 2'd1;
  localparam logic [1:0] ERR_ABNORMAL = 2'd2;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [13:0] target_position;
    logic [7:0]  rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        ready_res;
    logic [1:0]  error_code;
    logic [14:0] position;
    logic [7:0]  current;
    logic [7:0]  temperature;
  } out_word_t;

  // everything one processed item hands to the output serialiser
  typedef struct packed {
    logic                       has_tx;
    logic [1:0]                 count;
    logic [FrameLen-1:0][7:0]   frame;
    logic                       ready_res;
    logic [1:0]                 error_code;
    logic [14:0]                position;
    logic [7:0]                 current;
    logic [7:0]                 temperature;
  } burst_t;

endpackage

>>> rtl/ssam_core.sv
module ssam_core
  import ssam_pkg::*;
#(
  parameter int TIMEOUT_DEFAULT = TIMEOUT_RESET
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_word_t                in_word,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output logic                    burst_valid,
  input  logic                    burst_ready,
  output burst_t                  burst
);

  logic                     hold_valid;
  in_word_t                 hold;
  logic                     advance;

  logic [IdWidth-1:0]       servo_id;
  logic [TicksWidth-1:0]    timeout_ticks;

  logic [2:0]               pending;
  logic [13:0]              target_hold;
  logic [FrameLen-1:0][7:0] sent_frame;
  logic                     is_read;
  logic [2:0]               reply_index;
  logic                     receiving;
  logic [7:0]               high_part;
  logic [14:0]              position;
  logic [7:0]               current;
  logic [7:0]               temperature;
  logic [1:0]               error;
  logic [TicksWidth-1:0]    tick_count;

  logic [2:0]               pending_next;
  logic [13:0]              target_hold_next;
  logic [FrameLen-1:0][7:0] sent_frame_next;
  logic                     is_read_next;
  logic [2:0]               reply_index_next;
  logic                     receiving_next;
  logic [7:0]               high_part_next;
  logic [14:0]              position_next;
  logic [7:0]               current_next;
  logic [7:0]               temperature_next;
  logic [1:0]               error_next;
  logic [TicksWidth-1:0]    tick_count_next;
  logic [1:0]               nbytes;

  logic [7:0]               echo_byte;
  logic                     cmd_match;
  logic [TicksWidth-1:0]    tick_inc;

  assign in_stall    = hold_valid && !burst_ready;
  assign advance     = hold_valid && burst_ready;
  assign burst_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id      <= '0;
      timeout_ticks <= TicksWidth'(TIMEOUT_DEFAULT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SERVO_ID:      servo_id <= cfg_data[IdWidth-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TicksWidth-1:0];
        default: ;
      endcase
    end
  end

  assign echo_byte = sent_frame[reply_index[1:0]];
  assign cmd_match = (hold.rx_byte[6:0] == sent_frame[0][6:0]);
  assign tick_inc  = (tick_count == COUNT_MAX) ? tick_count : tick_count + TicksWidth'(1);

  always_comb begin
    pending_next     = pending;
    target_hold_next = target_hold;
    sent_frame_next  = sent_frame;
    is_read_next     = is_read;
    reply_index_next = reply_index;
    receiving_next   = receiving;
    high_part_next   = high_part;
    position_next    = position;
    current_next     = current;
    temperature_next = temperature;
    error_next       = error;
    tick_count_next  = tick_count;
    nbytes           = 2'd0;

    unique case (hold.func)
      FUNC_REQ_POS: begin
        error_next       = ERR_NONE;
        target_hold_next = hold.target_position;
        pending_next[0]  = 1'b1;
      end
      FUNC_REQ_CUR: begin
        error_next      = ERR_NONE;
        pending_next[1] = 1'b1;
      end
      FUNC_REQ_TEMP: begin
        error_next      = ERR_NONE;
        pending_next[2] = 1'b1;
      end
      FUNC_SEND: begin
        if (pending[0]) begin
          pending_next[0]    = 1'b0;
          is_read_next       = 1'b0;
          sent_frame_next[0] = CMD_POS | {3'b000, servo_id};
          sent_frame_next[1] = {1'b0, target_hold[13:7]};
          sent_frame_next[2] = {1'b0, target_hold[6:0]};
          nbytes             = 2'd3;
        end else if (pending[1]) begin
          pending_next[1]    = 1'b0;
          is_read_next       = 1'b1;
          sent_frame_next[0] = CMD_RD | {3'b000, servo_id};
          sent_frame_next[1] = SUB_CUR;
          nbytes             = 2'd2;
        end else if (pending[2]) begin
          pending_next[2]    = 1'b0;
          is_read_next       = 1'b1;
          sent_frame_next[0] = CMD_RD | {3'b000, servo_id};
          sent_frame_next[1] = SUB_TEMP;
          nbytes             = 2'd2;
        end
        if (nbytes != 2'd0) begin
          receiving_next   = 1'b1;
          reply_index_next = 3'd0;
          tick_count_next  = '0;
        end
      end
      FUNC_RX_BYTE: begin
        if (receiving) begin
          if (!is_read) begin
            // echo of three bytes, command, then two position bytes
            if (reply_index <= 3'd2) begin
              if (hold.rx_byte == echo_byte) begin
                reply_index_next = reply_index + 3'd1;
              end else begin
                error_next     = ERR_VERIFY;
                receiving_next = 1'b0;
              end
            end else if (reply_index == 3'd3) begin
              if (cmd_match) begin
                reply_index_next = 3'd4;
              end else begin
                error_next     = ERR_VERIFY;
                receiving_next = 1'b0;
              end
            end else if (reply_index == 3'd4) begin
              high_part_next   = hold.rx_byte;
              reply_index_next = 3'd5;
            end else if (reply_index == 3'd5) begin
              position_next  = {high_part, 7'b0} | {7'b0, hold.rx_byte};
              receiving_next = 1'b0;
            end else begin
              error_next     = ERR_ABNORMAL;
              receiving_next = 1'b0;
            end
          end else begin
            // echo of two bytes, command, subcommand, then the value
            if (reply_index <= 3'd1) begin
              if (hold.rx_byte == echo_byte) begin
                reply_index_next = reply_index + 3'd1;
              end else begin
                error_next     = ERR_VERIFY;
                receiving_next = 1'b0;
              end
            end else if (reply_index == 3'd2) begin
              if (cmd_match) begin
                reply_index_next = 3'd3;
              end else begin
                error_next     = ERR_VERIFY;
                receiving_next = 1'b0;
              end
            end else if (reply_index == 3'd3) begin
              if (hold.rx_byte == sent_frame[1]) begin
                reply_index_next = 3'd4;
              end else begin
                error_next     = ERR_VERIFY;
                receiving_next = 1'b0;
              end
            end else if (reply_index == 3'd4) begin
              if (sent_frame[1] == SUB_CUR) begin
                current_next = hold.rx_byte;
              end else if (sent_frame[1] == SUB_TEMP) begin
                temperature_next = hold.rx_byte;
              end
              receiving_next = 1'b0;
            end else begin
              error_next     = ERR_ABNORMAL;
              receiving_next = 1'b0;
            end
          end
        end
      end
      FUNC_TICK: begin
        if (receiving) begin
          tick_count_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            error_next     = ERR_TIMEOUT;
            receiving_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= '0;
      target_hold <= '0;
      sent_frame  <= '0;
      is_read     <= 1'b0;
      reply_index <= '0;
      receiving   <= 1'b0;
      high_part   <= '0;
      position    <= '0;
      current     <= '0;
      temperature <= '0;
      error       <= ERR_NONE;
      tick_count  <= '0;
    end else if (advance) begin
      pending     <= pending_next;
      target_hold <= target_hold_next;
      sent_frame  <= sent_frame_next;
      is_read     <= is_read_next;
      reply_index <= reply_index_next;
      receiving   <= receiving_next;
      high_part   <= high_part_next;
      position    <= position_next;
      current     <= current_next;
      temperature <= temperature_next;
      error       <= error_next;
      tick_count  <= tick_count_next;
    end
  end

  always_comb begin
    burst.has_tx      = (nbytes != 2'd0);
    burst.count       = (nbytes != 2'd0) ? nbytes : 2'd1;
    burst.frame       = sent_frame_next;
    burst.ready_res   = (pending_next == 3'd0) && !receiving_next;
    burst.error_code  = error_next;
    burst.position    = position_next;
    burst.current     = current_next;
    burst.temperature = temperature_next;
  end

  `ifndef SYNTHESIS
  // a position exchange never walks past the sixth reply byte
  assert property (@(posedge clk) disable iff (rst)
    receiving && !is_read |-> reply_index <= 3'd5)
    else $error("position reply index out of range");
  // a read exchange never walks past the fifth reply byte
  assert property (@(posedge clk) disable iff (rst)
    receiving && is_read |-> reply_index <= 3'd4)
    else $error("read reply index out of range");
  // an item that sends a frame always leaves the block receiving
  assert property (@(posedge clk) disable iff (rst)
    advance && burst.has_tx |=> receiving)
    else $error("frame sent without starting reception");
  `endif

endmodule

>>> rtl/ssam_out.sv
module ssam_out
  import ssam_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      burst_valid,
  output logic      burst_ready,
  input  burst_t    burst,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic        busy;
  burst_t      cur;
  logic [1:0]  word_idx;
  logic        last;
  logic        take;

  assign last        = (word_idx == cur.count - 2'd1);
  assign take        = out_valid && !out_stall;
  assign burst_ready = !busy || (take && last);
  assign out_valid   = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      word_idx <= '0;
    end else if (burst_ready) begin
      busy     <= burst_valid;
      word_idx <= '0;
    end else if (take) begin
      // advance to the next frame byte
      word_idx <= word_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_ready && burst_valid) begin
      cur <= burst;
    end
  end

  always_comb begin
    out_word.tx_valid    = cur.has_tx;
    out_word.tx_byte     = cur.has_tx ? cur.frame[word_idx] : 8'd0;
    out_word.tx_last     = last;
    out_word.ready_res   = cur.ready_res;
    out_word.error_code  = cur.error_code;
    out_word.position    = cur.position;
    out_word.current     = cur.current;
    out_word.temperature = cur.temperature;
  end

  `ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    busy |-> word_idx < cur.count)
    else $error("word index past end of burst");
  assert property (@(posedge clk) disable iff (rst)
    busy && !cur.has_tx |-> cur.count == 2'd1)
    else $error("status-only burst longer than one word");
  assert property (@(posedge clk) disable iff (rst)
    take && !last |=> busy && word_idx == $past(word_idx) + 2'd1)
    else $error("burst word skipped or lost");
  `endif

endmodule

>>> rtl/serial_servo_async_master_unit.sv
// Master of a half-duplex serial servo link. Each input word is a request
// (position, current, temperature), a send, a received line byte or a timeout
// tick; it is processed from the input register and gives one result word,
// or, for a send with a request pending, one word per frame byte (three for a
// position frame, two for a read frame) with tx_last on the final one. A new
// input word is taken every cycle while the result port keeps up; a send that
// emits a frame holds the input while the single result port emits one frame
// byte per cycle, unless out_stall holds it. Between acceptance and the first
// result lie the input hold register and the output burst register. The status
// fields show the state after the item and repeat on every word of a frame.
// The user must write configuration (servo_id, timeout_ticks) only while the
// block is idle; the block itself does not enforce this.
module serial_servo_async_master_unit
  import ssam_pkg::*;
#(
  parameter int TIMEOUT_DEFAULT = TIMEOUT_RESET
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_word_t                in_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_word_t               out_word,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  logic   burst_valid;
  logic   burst_ready;
  burst_t burst;

  ssam_core #(
    .TIMEOUT_DEFAULT(TIMEOUT_DEFAULT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .burst_valid(burst_valid),
    .burst_ready(burst_ready),
    .burst      (burst)
  );

  ssam_out u_out (
    .clk        (clk),
    .rst        (rst),
    .burst_valid(burst_valid),
    .burst_ready(burst_ready),
    .burst      (burst),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  `ifndef SYNTHESIS
  // a word carrying a frame byte always comes from an exchange in progress
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.tx_valid |-> !out_word.ready_res)
    else $error("frame byte while reporting ready");
  // only frames span several words
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.tx_last |-> out_word.tx_valid)
    else $error("status word not marked last");
  // an idle line slot carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.tx_valid |-> out_word.tx_byte == 8'd0)
    else $error("byte present on status word");
  `endif

endmodule
